### hw/rtl/wedm_pkg.sv
// Shared types, constants and helper functions for the weighted edit-distance matcher.
// Used by wedm_head_cell, wedm_cell and weighted_edit_distance_matcher_top.
package wedm_pkg;

    // Sizes
    localparam int PATTERN_MAX = 16;
    localparam int CHAR_W      = 8;
    localparam int COST_W      = 7;
    localparam int WEIGHT_W    = 4;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [COST_W-1:0] COST_CAP = {COST_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW   = 3'd0,
        CFG_PAT_HIGH  = 3'd1,
        CFG_PAT_LEN   = 3'd2,
        CFG_INS_COST  = 3'd3,
        CFG_DEL_COST  = 3'd4,
        CFG_SUB_COST  = 3'd5,
        CFG_THRESHOLD = 3'd6
    } t_cfg_index;

    // Input and result items
    typedef struct packed {
        logic [CHAR_W-1:0] word_char;
        logic              word_end;
    } t_in_item;

    typedef struct packed {
        logic [COST_W-1:0] distance;
        logic              is_match;
    } t_out_item;

    // Token handed from cell to cell; carries the costs captured at accept
    typedef struct packed {
        logic                   valid;
        logic                   start;   // first character of a word
        logic                   last;    // last character of a word
        logic [WEIGHT_W-1:0]    ins;
        logic [WEIGHT_W-1:0]    del;
        logic [WEIGHT_W-1:0]    subc;
        logic [LEN_W-1:0]       len;     // cells left before the distance tap
        logic [COST_W-1:0]      thr;
        logic [PATTERN_MAX-1:0] match;   // bit 0 is the next cell's compare
        logic [COST_W-1:0]      diag;    // previous cell's old column entry
        logic [COST_W-1:0]      above;   // previous cell's new column entry
        logic [COST_W-1:0]      word_cost;
    } t_token;

    // Saturating add of a weight to a cost
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                   input logic [WEIGHT_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {{(COST_W + 1 - WEIGHT_W){1'b0}}, b};
        return s[COST_W] ? COST_CAP : s[COST_W-1:0];
    endfunction

    // ASCII upper case to lower case, other bytes unchanged
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic [COST_W-1:0] min3(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b,
                                                input logic [COST_W-1:0] c);
        logic [COST_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

### hw/rtl/weighted_edit_distance_matcher_top.sv
// Top level of the weighted edit-distance matcher: config registers, chain, result register.
// Depends on wedm_pkg, wedm_head_cell and wedm_cell.
//
// The matcher takes one character item per cycle while the input is not stalled and
// returns one result item (distance, is_match) per word through a result register that
// is loaded when the word's last character leaves the chain. Each character walks a chain of
// one head cell and 16 pattern cells, one cell per cycle while not stalled, so up to 18
// characters are in flight; that chain sets the latency. The costs, pattern length, threshold
// and the per-character compare against the pattern are captured when a character
// is accepted. The input stalls only while a finished result waits in the output
// register and another word end has reached the end of the chain. No clearing pass
// after reset.
module weighted_edit_distance_matcher_top import wedm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_W-1:0]      r_pat_len;
    logic [WEIGHT_W-1:0]   r_ins_cost;
    logic [WEIGHT_W-1:0]   r_del_cost;
    logic [WEIGHT_W-1:0]   r_sub_cost;
    logic [COST_W-1:0]     r_threshold;

    logic                  r_in_word;
    t_token                r_tok0;
    t_token                n_tok0;
    t_token                w_chain [PATTERN_MAX+1:0];
    t_token                w_tail;
    logic                  w_advance;
    logic                  w_accept;
    logic [2*CFG_DATA_W-1:0] w_pat_all;
    logic [CHAR_W-1:0]     w_char_f;
    logic [PATTERN_MAX-1:0] w_match;
    logic [LEN_W-1:0]      w_len;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_pat_len   <= '0;
            r_ins_cost  <= WEIGHT_W'(1);
            r_del_cost  <= WEIGHT_W'(1);
            r_sub_cost  <= WEIGHT_W'(1);
            r_threshold <= COST_W'(2);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PAT_LOW:   r_pat_low   <= i_cfg_data;
                CFG_PAT_HIGH:  r_pat_high  <= i_cfg_data;
                CFG_PAT_LEN:   r_pat_len   <= i_cfg_data[LEN_W-1:0];
                CFG_INS_COST:  r_ins_cost  <= i_cfg_data[WEIGHT_W-1:0];
                CFG_DEL_COST:  r_del_cost  <= i_cfg_data[WEIGHT_W-1:0];
                CFG_SUB_COST:  r_sub_cost  <= i_cfg_data[WEIGHT_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[COST_W-1:0];
                default: ;
            endcase
        end
    end

    // Chain moves unless a word end would overrun a held result
    assign w_advance  = !(w_tail.valid && w_tail.last && r_out_valid && i_out_stall);
    assign o_in_stall = !w_advance;
    assign w_accept   = i_in_valid && w_advance;

    // Compare the character against every pattern position at once
    assign w_pat_all = {r_pat_high, r_pat_low};
    assign w_char_f  = fold(i_in_item.word_char);

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_match[i] = (fold(w_pat_all[CHAR_W*i +: CHAR_W]) == w_char_f);
        end
    end

    assign w_len = (r_pat_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_pat_len;

    // Entry token
    always_comb begin
        n_tok0       = '0;
        n_tok0.valid = w_accept;
        n_tok0.start = !r_in_word;
        n_tok0.last  = i_in_item.word_end;
        n_tok0.ins   = r_ins_cost;
        n_tok0.del   = r_del_cost;
        n_tok0.subc  = r_sub_cost;
        n_tok0.len   = w_len;
        n_tok0.thr   = r_threshold;
        n_tok0.match = w_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_tok0    <= '0;
        end else if (w_advance) begin
            r_tok0 <= n_tok0;
            if (w_accept) begin
                r_in_word <= !i_in_item.word_end;
            end
        end
    end

    // Cell chain
    assign w_chain[0] = r_tok0;

    wedm_head_cell u_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_tok     (w_chain[0]),
        .o_tok     (w_chain[1])
    );

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        wedm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_tok     (w_chain[g+1]),
            .o_tok     (w_chain[g+2])
        );
    end

    assign w_tail = w_chain[PATTERN_MAX+1];

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_tail.valid && w_tail.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_tail.valid && w_tail.last) begin
            r_out_item.distance <= w_tail.word_cost;
            r_out_item.is_match <= (w_tail.word_cost <= w_tail.thr);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A new result appears only after a word end left the chain
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(w_tail.valid && w_tail.last))
        else $error("result without a word end at the chain tail");

    // Input is held off only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // Accepting a word end closes the word
    a_word_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.word_end) |=> (!r_in_word && r_tok0.valid && r_tok0.last))
        else $error("word end did not close the word");

endmodule

### hw/rtl/wedm_head_cell.sv
// Head cell of the matcher chain: holds the top entry of the cost column.
// Depends on wedm_pkg.
module wedm_head_cell import wedm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  t_token i_tok,
    output t_token o_tok
);

    logic [COST_W-1:0] r_top;
    t_token            r_tok;
    t_token            n_tok;
    logic [COST_W-1:0] w_old;
    logic [COST_W-1:0] w_top;

    // Top entry restarts at zero at a word start, then grows by the insert cost
    assign w_old = i_tok.start ? '0 : r_top;
    assign w_top = sat_add(w_old, i_tok.ins);

    always_comb begin
        n_tok       = i_tok;
        n_tok.diag  = w_old;
        n_tok.above = w_top;
        // Empty pattern: distance is the top entry
        if (i_tok.len == '0) begin
            n_tok.word_cost = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_tok <= '0;
        end else if (i_advance) begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_top <= w_top;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

### hw/rtl/wedm_cell.sv
// One pattern cell of the matcher chain: holds one entry of the cost column.
// Depends on wedm_pkg.
module wedm_cell import wedm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  t_token i_tok,
    output t_token o_tok
);

    logic [COST_W-1:0] r_col;
    t_token            r_tok;
    t_token            n_tok;
    logic [COST_W-1:0] w_old;
    logic [COST_W-1:0] w_sub;
    logic [COST_W-1:0] w_val;

    // At a word start the entry is rebuilt from the neighbor's rebuilt entry
    assign w_old = i_tok.start ? sat_add(i_tok.diag, i_tok.del) : r_col;
    assign w_sub = sat_add(i_tok.diag, i_tok.match[0] ? '0 : i_tok.subc);
    assign w_val = min3(w_sub, sat_add(i_tok.above, i_tok.del), sat_add(w_old, i_tok.ins));

    always_comb begin
        n_tok       = i_tok;
        n_tok.diag  = w_old;
        n_tok.above = w_val;
        n_tok.match = i_tok.match >> 1;
        n_tok.len   = (i_tok.len == '0) ? '0 : i_tok.len - 1'b1;
        // This cell is the one the pattern length points at
        if (i_tok.len == LEN_W'(1)) begin
            n_tok.word_cost = w_val;
        end
    end

    // Token valid needs reset; the column entry is rebuilt before use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_tok.valid) begin
            r_col <= w_val;
        end
    end

    assign o_tok = r_tok;

endmodule
